/* rtl/qbaa_pkg.sv */
package qbaa_pkg;

    // Transaction mode codes
    localparam logic MODE_ALLOC   = 1'b0;
    localparam logic MODE_RELEASE = 1'b1;

    // Sibling group of the quadtree
    localparam int KID_COUNT = 4;

    // Sequencer states
    typedef enum logic [6:0] {
        ST_CLEAR  = 7'b0000001,
        ST_IDLE   = 7'b0000010,
        ST_ROOT   = 7'b0000100,
        ST_DESC   = 7'b0001000,
        ST_MARK   = 7'b0010000,
        ST_REPAIR = 7'b0100000,
        ST_DONE   = 7'b1000000
    } t_state;

endpackage

/* rtl/quadtree_buddy_area_allocator.sv */
// Two-dimensional buddy allocator over a square of 2^(TREE_LEVELS-1) atoms a side. The
// level masks of all NODE_TOTAL quadtree nodes live in one single-port-read RAM with a
// registered read. After reset the block clears that RAM to all free, one node per cycle,
// and holds o_ready low until all NODE_TOTAL nodes are cleared. Every transaction gives
// exactly one result. An allocate of level s descends s levels and then repairs up to s
// ancestors; a release of a level-s node repairs up to s ancestors. The time a transaction
// takes is set by the RAM read port: every descent or repair step reads four sibling masks
// (and, when repairing, the parent) one after the other. One result can wait in the output
// register while the next transaction is accepted and worked on.
module quadtree_buddy_area_allocator #(
    parameter int TREE_LEVELS = 8,
    parameter int NODE_TOTAL  = 21845
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic                              i_mode,
    input  logic [2:0]                        i_scale,
    input  logic [$clog2(NODE_TOTAL+1)-1:0]   i_node_index,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic                              o_granted,
    output logic [TREE_LEVELS-2:0]            o_pos_x,
    output logic [TREE_LEVELS-2:0]            o_pos_y,
    output logic [$clog2(NODE_TOTAL+1)-1:0]   o_granted_node
);

    localparam int ML = TREE_LEVELS;
    localparam int AW = $clog2(NODE_TOTAL);
    localparam int NW = $clog2(NODE_TOTAL + 1);
    localparam int PW = TREE_LEVELS - 1;
    localparam int LW = $clog2(TREE_LEVELS);
    localparam logic [ML-1:0] ALL_FREE = {ML{1'b1}};

    // First node index of level l, counted down from the end of the array
    function automatic int level_bound(input int l);
        int sum;
        sum = 0;
        for (int j = l; j < TREE_LEVELS; j++) begin
            sum = sum + (1 << (2 * j));
        end
        return NODE_TOTAL - sum;
    endfunction

    qbaa_pkg::t_state r_state, n_state;

    logic [AW-1:0]  r_clr;
    logic           r_mode;
    logic [LW-1:0]  r_scale;
    logic [LW-1:0]  r_cur;
    logic [LW-1:0]  r_lvl;
    logic [AW-1:0]  r_node;
    logic [AW-1:0]  r_first;
    logic [AW-1:0]  r_par;
    logic [2:0]     r_cnt;
    logic [ML-1:0]  r_buf [qbaa_pkg::KID_COUNT];
    logic [PW-1:0]  r_x;
    logic [PW-1:0]  r_y;
    logic           r_granted;

    logic           r_o_valid;
    logic           r_o_granted;
    logic [PW-1:0]  r_o_x;
    logic [PW-1:0]  r_o_y;
    logic [NW-1:0]  r_o_node;

    logic           wr_en;
    logic [AW-1:0]  wr_addr;
    logic [ML-1:0]  wr_data;
    logic [AW-1:0]  rd_addr;
    logic [ML-1:0]  rd_data;

    logic           in_acc;
    logic           out_load;
    logic           in_range;
    logic [LW-1:0]  idx_lvl;
    logic [ML-1:0]  want_bit;
    logic [ML-1:0]  kid [qbaa_pkg::KID_COUNT];
    logic           pick_found;
    logic [1:0]     pick_q;
    logic [AW-1:0]  pick_node;
    logic [PW-1:0]  pos_bit;
    logic           last_step;
    logic [ML-1:0]  rep_or;
    logic [ML-1:0]  rep_and;
    logic [ML-1:0]  rep_low;
    logic [ML-1:0]  rep_val;
    logic [AW-1:0]  par_dec;

    qbaa_ram #(
        .WIDTH (ML),
        .DEPTH (NODE_TOTAL)
    ) u_qbaa_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign o_ready  = (r_state == qbaa_pkg::ST_IDLE);
    assign in_acc   = i_valid && o_ready;
    assign out_load = (r_state == qbaa_pkg::ST_DONE) && (!r_o_valid || i_ready);
    assign in_range = (i_node_index < NW'(NODE_TOTAL));

    // Level of the node to release
    always_comb begin
        idx_lvl = '0;
        for (int l = 1; l < TREE_LEVELS; l++) begin
            if (int'(i_node_index) >= level_bound(l)) begin
                idx_lvl = LW'(l);
            end
        end
    end

    // Choose the first child holding the requested level
    always_comb begin
        want_bit = ML'(1) << r_scale;
        for (int q = 0; q < qbaa_pkg::KID_COUNT - 1; q++) begin
            kid[q] = r_buf[q];
        end
        kid[qbaa_pkg::KID_COUNT-1] = (r_state == qbaa_pkg::ST_DESC) ?
                                     rd_data : r_buf[qbaa_pkg::KID_COUNT-1];
        pick_found = 1'b0;
        pick_q     = '0;
        for (int q = qbaa_pkg::KID_COUNT - 1; q >= 0; q--) begin
            if ((kid[q] & want_bit) != '0) begin
                pick_found = 1'b1;
                pick_q     = 2'(q);
            end
        end
        pick_node = r_first + AW'(pick_q);
        pos_bit   = '0;
        for (int b = 0; b < PW; b++) begin
            if (b == PW - 1 - int'(r_cur)) begin
                pos_bit[b] = 1'b1;
            end
        end
        last_step = (LW'(r_cur + 1'b1) == r_scale);
    end

    // Rebuild the parent mask from its four children
    always_comb begin
        rep_or  = '0;
        rep_and = ALL_FREE;
        for (int q = 0; q < qbaa_pkg::KID_COUNT; q++) begin
            rep_or  = rep_or | kid[q];
            rep_and = rep_and & kid[q];
        end
        for (int b = 0; b < ML; b++) begin
            rep_low[b] = (b < int'(r_lvl));
        end
        rep_val = rep_or;
        if (!rep_and[LW'(r_lvl - 1'b1)]) begin
            rep_val = rep_or & ~rep_low;
        end
        par_dec = AW'((r_par - 1'b1) >> 2);
    end

    // Drive the memory ports
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_node;
        wr_data = '0;
        rd_addr = '0;
        case (r_state)
            qbaa_pkg::ST_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = r_clr;
                wr_data = ALL_FREE;
            end
            qbaa_pkg::ST_DESC: begin
                rd_addr = r_first + AW'(r_cnt[1:0]);
            end
            qbaa_pkg::ST_MARK: begin
                wr_en   = 1'b1;
                wr_data = (r_mode == qbaa_pkg::MODE_RELEASE) ? ALL_FREE : '0;
            end
            qbaa_pkg::ST_REPAIR: begin
                rd_addr = (r_cnt < 3'd4) ? r_first + AW'(r_cnt[1:0]) : r_par;
                if (r_cnt == 3'd5 && rep_val != rd_data) begin
                    wr_en   = 1'b1;
                    wr_addr = r_par;
                    wr_data = rep_val;
                end
            end
            default: begin
                rd_addr = '0;
            end
        endcase
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            qbaa_pkg::ST_CLEAR: begin
                if (r_clr == AW'(NODE_TOTAL - 1)) begin
                    n_state = qbaa_pkg::ST_IDLE;
                end
            end
            qbaa_pkg::ST_IDLE: begin
                if (in_acc) begin
                    if (i_mode == qbaa_pkg::MODE_RELEASE) begin
                        n_state = in_range ? qbaa_pkg::ST_MARK : qbaa_pkg::ST_DONE;
                    end else begin
                        n_state = (int'(i_scale) >= TREE_LEVELS) ?
                                  qbaa_pkg::ST_DONE : qbaa_pkg::ST_ROOT;
                    end
                end
            end
            qbaa_pkg::ST_ROOT: begin
                if ((rd_data & want_bit) == '0) begin
                    n_state = qbaa_pkg::ST_DONE;
                end else if (r_scale == '0) begin
                    n_state = qbaa_pkg::ST_MARK;
                end else begin
                    n_state = qbaa_pkg::ST_DESC;
                end
            end
            qbaa_pkg::ST_DESC: begin
                if (r_cnt == 3'd4) begin
                    if (!pick_found) begin
                        n_state = qbaa_pkg::ST_DONE;
                    end else if (last_step) begin
                        n_state = qbaa_pkg::ST_MARK;
                    end
                end
            end
            qbaa_pkg::ST_MARK: begin
                n_state = (r_lvl == '0) ? qbaa_pkg::ST_DONE : qbaa_pkg::ST_REPAIR;
            end
            qbaa_pkg::ST_REPAIR: begin
                if (r_cnt == 3'd5 && (rep_val == rd_data || r_par == '0)) begin
                    n_state = qbaa_pkg::ST_DONE;
                end
            end
            qbaa_pkg::ST_DONE: begin
                if (out_load) begin
                    n_state = qbaa_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = qbaa_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= qbaa_pkg::ST_CLEAR;
            r_clr     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == qbaa_pkg::ST_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (out_load) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Working registers of the transaction in progress
    always_ff @(posedge i_clk) begin
        if (r_state == qbaa_pkg::ST_DESC || r_state == qbaa_pkg::ST_REPAIR) begin
            if (r_cnt != 3'd0 && r_cnt <= 3'd4) begin
                r_buf[2'(r_cnt - 3'd1)] <= rd_data;
            end
        end
        case (r_state)
            qbaa_pkg::ST_IDLE: begin
                r_mode    <= i_mode;
                r_scale   <= LW'(i_scale);
                r_cur     <= '0;
                r_node    <= AW'(i_node_index);
                r_lvl     <= idx_lvl;
                r_first   <= AW'(1);
                r_cnt     <= '0;
                r_x       <= '0;
                r_y       <= '0;
                r_granted <= 1'b0;
            end
            qbaa_pkg::ST_ROOT: begin
                r_node <= '0;
                r_lvl  <= r_scale;
            end
            qbaa_pkg::ST_DESC: begin
                if (r_cnt == 3'd4) begin
                    r_cnt   <= '0;
                    r_node  <= pick_node;
                    r_first <= AW'({pick_node, 2'b01});
                    r_cur   <= LW'(r_cur + 1'b1);
                    if (pick_q[0]) begin
                        r_x <= r_x | pos_bit;
                    end
                    if (pick_q[1]) begin
                        r_y <= r_y | pos_bit;
                    end
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            qbaa_pkg::ST_MARK: begin
                r_granted <= (r_mode == qbaa_pkg::MODE_ALLOC);
                r_par     <= AW'((r_node - 1'b1) >> 2);
                r_first   <= AW'({AW'((r_node - 1'b1) >> 2), 2'b01});
                r_cnt     <= '0;
            end
            qbaa_pkg::ST_REPAIR: begin
                if (r_cnt == 3'd5) begin
                    r_cnt   <= '0;
                    r_lvl   <= LW'(r_lvl - 1'b1);
                    r_par   <= par_dec;
                    r_first <= AW'({par_dec, 2'b01});
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            default: begin
                r_cnt <= r_cnt;
            end
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_granted <= r_granted;
            r_o_x       <= r_granted ? r_x : '0;
            r_o_y       <= r_granted ? r_y : '0;
            r_o_node    <= r_granted ? NW'(r_node) : '0;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_granted      = r_o_granted;
    assign o_pos_x        = r_o_x;
    assign o_pos_y        = r_o_y;
    assign o_granted_node = r_o_node;

endmodule

/* rtl/qbaa_ram.sv */
module qbaa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 21845
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/qbaa_checker.sv */
module qbaa_checker #(
    parameter int TREE_LEVELS = 8,
    parameter int NODE_TOTAL  = 21845
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  logic                            o_ready,
    input  logic                            i_mode,
    input  logic                            o_valid,
    input  logic                            i_ready,
    input  logic                            o_granted,
    input  logic [TREE_LEVELS-2:0]          o_pos_x,
    input  logic [TREE_LEVELS-2:0]          o_pos_y,
    input  logic [$clog2(NODE_TOTAL+1)-1:0] o_granted_node
);

    logic       in_acc;
    logic       out_acc;
    logic       to_head;
    logic [1:0] r_cnt;
    logic       r_q0;
    logic       r_q1;

    assign in_acc  = i_valid && o_ready;
    assign out_acc = o_valid && i_ready;
    assign to_head = (r_cnt - 2'(out_acc) == 2'd0);

    // Track modes of the transactions still owed a result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= r_cnt + 2'(in_acc) - 2'(out_acc);
        end
        if (in_acc && to_head) begin
            r_q0 <= i_mode;
        end else if (out_acc) begin
            r_q0 <= r_q1;
        end
        if (in_acc && !to_head) begin
            r_q1 <= i_mode;
        end
    end

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_granted) && $stable(o_pos_x)
            && $stable(o_pos_y) && $stable(o_granted_node))
        else $error("result changed while stalled");

    // At most two transactions in flight, and no result without one
    a_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt <= 2'd2) && !(out_acc && r_cnt == 2'd0))
        else $error("result count does not match accepted transactions");

    // A release always returns an empty result
    a_release_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc && r_cnt != 2'd0 && r_q0 == qbaa_pkg::MODE_RELEASE |-> !o_granted)
        else $error("release returned a grant");

    // An empty result, from a refused allocate or a release, carries no position or node
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_granted |-> o_pos_x == '0 && o_pos_y == '0 && o_granted_node == '0)
        else $error("empty result carries data");

endmodule

bind quadtree_buddy_area_allocator qbaa_checker #(
    .TREE_LEVELS (TREE_LEVELS),
    .NODE_TOTAL  (NODE_TOTAL)
) u_qbaa_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_ready        (o_ready),
    .i_mode         (i_mode),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_granted      (o_granted),
    .o_pos_x        (o_pos_x),
    .o_pos_y        (o_pos_y),
    .o_granted_node (o_granted_node)
);
